// ===== hdl/pcs_pkg.sv =====
// Shared types, widths and helpers for the polygon centroid block.
package pcs_pkg;

    localparam int COORD_W  = 16;
    localparam int AREA_W   = 43;
    localparam int WSUM_W   = 61;
    localparam int OUT_W    = 24;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int SUM_W    = COORD_W + 1;
    localparam int WPROD_W  = SUM_W + CROSS_W;
    localparam int DEN_W    = AREA_W + 2;
    localparam int QUOT_W   = OUT_W + 1;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_FRAC_BITS    = 8;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_OVF  = 2'd2
    } status_t;

    typedef struct packed {
        logic    load;
        logic    take_first;
        logic    mark_ovf;
        logic    prod;
        logic    xprod;
        logic    wmul;
        logic    acc;
        logic    adv;
        logic    close;
        logic    div_init;
        logic    div_step;
        logic    emit;
        status_t code;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic cnt_zero;
        logic cnt_below;
        logic cnt_over;
        logic area_zero;
        logic div_last;
        logic out_free;
    } sts_t;

    // Saturate a quotient magnitude to the signed output range and apply the sign.
    function automatic logic [OUT_W-1:0] sat_quot(input logic [QUOT_W-1:0] q,
                                                  input logic ovf, input logic neg);
        logic big;
        big = ovf | q[QUOT_W-1] | q[QUOT_W-2];
        if (neg) begin
            sat_quot = big ? {1'b1, {(OUT_W-1){1'b0}}} : (~q[OUT_W-1:0] + 1'b1);
        end else begin
            sat_quot = big ? {1'b0, {(OUT_W-1){1'b1}}} : q[OUT_W-1:0];
        end
    endfunction

endpackage

// ===== hdl/polygon_centroid_shoelace.sv =====
// Top level of the polygon centroid and doubled area block.
// Vertices arrive one beat at a time as signed 16-bit coordinates, the beat with
// last_vertex high closing the polygon. No new beat is taken while the controller
// walks the edge ending at each vertex after the first through two multiply
// stages, a subtract and an accumulate; the first vertex of a polygon and any
// vertex beyond MAX_VERTICES skip this edge arithmetic. The last vertex then
// runs the closing edge, a zero-area check, and two parallel bit-serial dividers
// on dividends of 61 + FRAC_BITS bits, before one result beat is loaded into
// the output register. That register frees the input side, so a new polygon
// may start while a result still waits for m_ready. The result holds the
// centroid as the weighted vertex sums divided by three times the doubled area,
// in fixed point with FRAC_BITS fraction bits, truncated toward zero and
// saturated to 24 bits, together with the doubled signed area and a status
// code. A polygon of zero area reports status 1 with zero outputs; more than
// MAX_VERTICES vertices reports status 2 with zero outputs, extra vertices
// being ignored.
module polygon_centroid_shoelace #(
    parameter int MAX_VERTICES = pcs_pkg::DEF_MAX_VERTICES,
    parameter int FRAC_BITS    = pcs_pkg::DEF_FRAC_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [pcs_pkg::COORD_W-1:0] s_x_coord,
    input  logic signed [pcs_pkg::COORD_W-1:0] s_y_coord,
    input  logic                               s_last_vertex,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [pcs_pkg::OUT_W-1:0]   m_centroid_x,
    output logic signed [pcs_pkg::OUT_W-1:0]   m_centroid_y,
    output logic signed [pcs_pkg::AREA_W-1:0]  m_doubled_area,
    output logic [1:0]                         m_status
);
    import pcs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // The controller sequences edge arithmetic, the division and the result load.
    pcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds all vertex state, accumulators and the output register.
    pcs_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .FRAC_BITS    (FRAC_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_x_coord      (s_x_coord),
        .s_y_coord      (s_y_coord),
        .s_last_vertex  (s_last_vertex),
        .cmd            (cmd),
        .sts            (sts),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_centroid_x   (m_centroid_x),
        .m_centroid_y   (m_centroid_y),
        .m_doubled_area (m_doubled_area),
        .m_status       (m_status)
    );

endmodule

// ===== hdl/pcs_ctrl.sv =====
// Sequencer for the polygon centroid block.
module pcs_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pcs_pkg::sts_t sts,
    output pcs_pkg::cmd_t cmd
);
    import pcs_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CHECK = 11'b00000000010,
        S_PROD  = 11'b00000000100,
        S_CROSS = 11'b00000001000,
        S_WMUL  = 11'b00000010000,
        S_ACC   = 11'b00000100000,
        S_TAIL  = 11'b00001000000,
        S_ZTEST = 11'b00010000000,
        S_DINIT = 11'b00100000000,
        S_DIV   = 11'b01000000000,
        S_EMIT  = 11'b10000000000
    } state_t;

    state_t  state_reg, state_next;
    logic    closing_reg, closing_next;
    status_t code_reg, code_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            closing_reg <= 1'b0;
            code_reg    <= ST_OK;
        end else begin
            state_reg   <= state_next;
            closing_reg <= closing_next;
            code_reg    <= code_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        closing_next = closing_reg;
        code_next    = code_reg;
        cmd          = '0;
        cmd.close    = closing_reg;
        cmd.code     = code_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load     = 1'b1;
                    closing_next = 1'b0;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.cnt_zero) begin
                    cmd.take_first = 1'b1;
                    state_next     = S_TAIL;
                end else if (sts.cnt_below) begin
                    state_next = S_PROD;
                end else begin
                    cmd.mark_ovf = 1'b1;
                    state_next   = S_TAIL;
                end
            end
            S_PROD: begin
                cmd.prod   = 1'b1;
                state_next = S_CROSS;
            end
            S_CROSS: begin
                cmd.xprod  = 1'b1;
                state_next = S_WMUL;
            end
            S_WMUL: begin
                cmd.wmul   = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.acc    = 1'b1;
                cmd.adv    = !closing_reg;
                state_next = closing_reg ? S_ZTEST : S_TAIL;
            end
            S_TAIL: begin
                if (!sts.last) begin
                    state_next = S_IDLE;
                end else if (sts.cnt_over) begin
                    code_next  = ST_OVF;
                    state_next = S_EMIT;
                end else begin
                    closing_next = 1'b1;
                    state_next   = S_PROD;
                end
            end
            S_ZTEST: begin
                if (sts.area_zero) begin
                    code_next  = ST_ZERO;
                    state_next = S_EMIT;
                end else begin
                    code_next  = ST_OK;
                    state_next = S_DINIT;
                end
            end
            S_DINIT: begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/pcs_datapath.sv =====
// Datapath: vertex registers, shoelace accumulators, dividers and output register.
module pcs_datapath #(
    parameter int MAX_VERTICES = pcs_pkg::DEF_MAX_VERTICES,
    parameter int FRAC_BITS    = pcs_pkg::DEF_FRAC_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic signed [pcs_pkg::COORD_W-1:0]  s_x_coord,
    input  logic signed [pcs_pkg::COORD_W-1:0]  s_y_coord,
    input  logic                                s_last_vertex,
    input  pcs_pkg::cmd_t                       cmd,
    output pcs_pkg::sts_t                       sts,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [pcs_pkg::OUT_W-1:0]    m_centroid_x,
    output logic signed [pcs_pkg::OUT_W-1:0]    m_centroid_y,
    output logic signed [pcs_pkg::AREA_W-1:0]   m_doubled_area,
    output logic [1:0]                          m_status
);
    import pcs_pkg::*;

    localparam int CNT_W  = $clog2(MAX_VERTICES + 2);
    localparam int DIV_W  = WSUM_W + FRAC_BITS;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    logic signed [COORD_W-1:0] vx_reg, vy_reg, fx_reg, fy_reg, px_reg, py_reg;
    logic                      last_reg;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;

    logic signed [PROD_W-1:0]  m1_reg, m2_reg;
    logic signed [SUM_W-1:0]   sx_reg, sy_reg;
    logic signed [CROSS_W-1:0] a_reg;
    logic signed [WPROD_W-1:0] wx_reg, wy_reg;
    logic signed [AREA_W-1:0]  area_reg;
    logic signed [WSUM_W-1:0]  wsx_reg, wsy_reg;

    logic signed [COORD_W-1:0] qx, qy;

    logic [DIV_W-1:0]  dx_reg, dy_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rx_reg, ry_reg, rx_next, ry_next;
    logic [QUOT_W-1:0] qx_reg, qy_reg;
    logic              ovx_reg, ovy_reg, negx_reg, negy_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [DEN_W:0]    rx2, ry2;
    logic              gex, gey;

    logic [WSUM_W-1:0] magx, magy;
    logic [AREA_W-1:0] maga;

    logic m_valid_reg;
    logic signed [OUT_W-1:0]  cx_reg, cy_reg;
    logic signed [AREA_W-1:0] da_reg;
    logic [1:0]               st_reg;
    logic                     ok;

    assign qx = cmd.close ? fx_reg : vx_reg;
    assign qy = cmd.close ? fy_reg : vy_reg;

    assign magx = wsx_reg[WSUM_W-1] ? WSUM_W'(-wsx_reg) : WSUM_W'(wsx_reg);
    assign magy = wsy_reg[WSUM_W-1] ? WSUM_W'(-wsy_reg) : WSUM_W'(wsy_reg);
    assign maga = area_reg[AREA_W-1] ? AREA_W'(-area_reg) : AREA_W'(area_reg);

    // One restoring step per cycle on each of the two quotients.
    assign rx2 = {rx_reg, dx_reg[DIV_W-1]};
    assign ry2 = {ry_reg, dy_reg[DIV_W-1]};
    assign gex = rx2 >= {1'b0, den_reg};
    assign gey = ry2 >= {1'b0, den_reg};
    assign rx_next = gex ? DEN_W'(rx2 - {1'b0, den_reg}) : rx2[DEN_W-1:0];
    assign ry_next = gey ? DEN_W'(ry2 - {1'b0, den_reg}) : ry2[DEN_W-1:0];

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.emit) begin
            cnt_next = '0;
        end else if (cmd.take_first) begin
            cnt_next = CNT_W'(1);
        end else if (cmd.mark_ovf) begin
            cnt_next = CNT_W'(MAX_VERTICES + 1);
        end else if (cmd.adv) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            fx_reg      <= '0;
            fy_reg      <= '0;
            px_reg      <= '0;
            py_reg      <= '0;
            area_reg    <= '0;
            wsx_reg     <= '0;
            wsy_reg     <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.emit) begin
                fx_reg   <= '0;
                fy_reg   <= '0;
                px_reg   <= '0;
                py_reg   <= '0;
                area_reg <= '0;
                wsx_reg  <= '0;
                wsy_reg  <= '0;
            end else begin
                if (cmd.take_first) begin
                    fx_reg <= vx_reg;
                    fy_reg <= vy_reg;
                end
                if (cmd.take_first || cmd.adv) begin
                    px_reg <= vx_reg;
                    py_reg <= vy_reg;
                end
                if (cmd.acc) begin
                    area_reg <= area_reg + AREA_W'(a_reg);
                    wsx_reg  <= wsx_reg + WSUM_W'(wx_reg);
                    wsy_reg  <= wsy_reg + WSUM_W'(wy_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            vx_reg   <= s_x_coord;
            vy_reg   <= s_y_coord;
            last_reg <= s_last_vertex;
        end
        if (cmd.prod) begin
            m1_reg <= px_reg * qy;
            m2_reg <= qx * py_reg;
            sx_reg <= SUM_W'(px_reg) + SUM_W'(qx);
            sy_reg <= SUM_W'(py_reg) + SUM_W'(qy);
        end
        if (cmd.xprod) begin
            a_reg <= CROSS_W'(m1_reg) - CROSS_W'(m2_reg);
        end
        if (cmd.wmul) begin
            wx_reg <= sx_reg * a_reg;
            wy_reg <= sy_reg * a_reg;
        end
        if (cmd.div_init) begin
            dx_reg   <= DIV_W'(magx) << FRAC_BITS;
            dy_reg   <= DIV_W'(magy) << FRAC_BITS;
            den_reg  <= DEN_W'({maga, 1'b0}) + DEN_W'(maga);
            rx_reg   <= '0;
            ry_reg   <= '0;
            qx_reg   <= '0;
            qy_reg   <= '0;
            ovx_reg  <= 1'b0;
            ovy_reg  <= 1'b0;
            negx_reg <= wsx_reg[WSUM_W-1] ^ area_reg[AREA_W-1];
            negy_reg <= wsy_reg[WSUM_W-1] ^ area_reg[AREA_W-1];
            dcnt_reg <= DCNT_W'(DIV_W);
        end else if (cmd.div_step) begin
            dx_reg   <= dx_reg << 1;
            dy_reg   <= dy_reg << 1;
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            qx_reg   <= {qx_reg[QUOT_W-2:0], gex};
            qy_reg   <= {qy_reg[QUOT_W-2:0], gey};
            ovx_reg  <= ovx_reg | qx_reg[QUOT_W-1];
            ovy_reg  <= ovy_reg | qy_reg[QUOT_W-1];
            dcnt_reg <= dcnt_reg - 1'b1;
        end
        if (cmd.emit) begin
            cx_reg <= ok ? sat_quot(qx_reg, ovx_reg, negx_reg) : '0;
            cy_reg <= ok ? sat_quot(qy_reg, ovy_reg, negy_reg) : '0;
            da_reg <= ok ? area_reg : '0;
            st_reg <= cmd.code;
        end
    end

    assign ok = (cmd.code == ST_OK);

    assign sts.last      = last_reg;
    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.cnt_below = (cnt_reg < CNT_W'(MAX_VERTICES));
    assign sts.cnt_over  = (cnt_reg > CNT_W'(MAX_VERTICES));
    assign sts.area_zero = (area_reg == '0);
    assign sts.div_last  = (dcnt_reg == DCNT_W'(1));
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_centroid_x   = cx_reg;
    assign m_centroid_y   = cy_reg;
    assign m_doubled_area = da_reg;
    assign m_status       = st_reg;

endmodule

// ===== tb/polygon_centroid_shoelace_test.sv =====
// Self-checking testbench for the polygon centroid and doubled area block.
`timescale 1ns / 1ps

module polygon_centroid_shoelace_test;

    import pcs_pkg::*;

    localparam int MAX_V      = DEF_MAX_VERTICES;
    localparam int FRAC       = DEF_FRAC_BITS;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_LEN   = 1500;
    localparam int DRAIN_LEN  = 300;

    // One expected result beat.
    typedef struct {
        logic [OUT_W-1:0]  cx;
        logic [OUT_W-1:0]  cy;
        logic [AREA_W-1:0] da;
        status_t           st;
    } centroid_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_x_coord;
    logic signed [COORD_W-1:0] s_y_coord;
    logic                      s_last_vertex;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [OUT_W-1:0]   m_centroid_x;
    logic signed [OUT_W-1:0]   m_centroid_y;
    logic signed [AREA_W-1:0]  m_doubled_area;
    logic [1:0]                m_status;

    polygon_centroid_shoelace i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_x_coord     (s_x_coord),
        .s_y_coord     (s_y_coord),
        .s_last_vertex (s_last_vertex),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_centroid_x  (m_centroid_x),
        .m_centroid_y  (m_centroid_y),
        .m_doubled_area(m_doubled_area),
        .m_status      (m_status)
    );

    // Shadow copy of the polygon accumulator state.
    longint                   poly_first_x, poly_first_y, poly_prev_x, poly_prev_y;
    int                       poly_count;
    logic signed [AREA_W-1:0] poly_area;
    logic signed [WSUM_W-1:0] poly_wx, poly_wy;

    centroid_t pending_centroids[$];
    int        fail_count;
    int        idle_pct;
    int        stall_pct;
    bit        ready_hold;
    int        quiet_cycles;

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Receiver: ready toggles at random unless a long hold-off is in progress.
    always @(posedge aclk) begin
        if (ready_hold) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: counts cycles in which neither channel moves a beat. All
    // handshakes are sampled at the falling edge, where every signal is stable.
    always @(negedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("polygon_centroid_shoelace regression: fail");
            $finish;
        end
    end

    // Result checker: each result beat is compared with the oldest prediction.
    always @(negedge aclk) begin
        centroid_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_centroids.size() == 0) begin
                $error("unexpected result beat: status %0d", m_status);
                fail_count++;
            end else begin
                want = pending_centroids.pop_front();
                if (m_centroid_x !== want.cx) begin
                    $error("centroid_x expected %0h actual %0h", want.cx, m_centroid_x);
                    fail_count++;
                end
                if (m_centroid_y !== want.cy) begin
                    $error("centroid_y expected %0h actual %0h", want.cy, m_centroid_y);
                    fail_count++;
                end
                if (m_doubled_area !== want.da) begin
                    $error("doubled_area expected %0h actual %0h", want.da, m_doubled_area);
                    fail_count++;
                end
                if (m_status !== want.st) begin
                    $error("status expected %0d actual %0d", want.st, m_status);
                    fail_count++;
                end
            end
        end
    end

    function automatic void clear_polygon();
        poly_first_x = 0;
        poly_first_y = 0;
        poly_prev_x  = 0;
        poly_prev_y  = 0;
        poly_count   = 0;
        poly_area    = '0;
        poly_wx      = '0;
        poly_wy      = '0;
    endfunction

    // Adds one edge's cross product and weighted sums; all sums wrap at their widths.
    function automatic void add_edge(longint px, longint py, longint qx, longint qy);
        longint cross_prod;
        cross_prod = px * qy - qx * py;
        poly_area  = poly_area + cross_prod[AREA_W-1:0];
        poly_wx    = poly_wx + WSUM_W'((px + qx) * cross_prod);
        poly_wy    = poly_wy + WSUM_W'((py + qy) * cross_prod);
    endfunction

    // Truncated fixed-point quotient num * 2^FRAC / den, saturated to OUT_W bits.
    function automatic longint fixed_quotient(longint num, longint den);
        bit              neg;
        longint unsigned n, d, q, r, lim;
        neg = (num < 0) != (den < 0);
        n   = (num < 0) ? -num : num;
        d   = (den < 0) ? -den : den;
        lim = 64'd1 << (OUT_W - 1);
        q   = n / d;
        r   = n % d;
        if (q > (lim >> FRAC)) begin
            q = lim;
        end else begin
            for (int i = 0; i < FRAC; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= d) begin
                    r = r - d;
                    q = q | 1;
                end
            end
        end
        if (neg) begin
            return (q > lim) ? -longint'(lim) : -longint'(q);
        end
        return (q > lim - 1) ? longint'(lim - 1) : longint'(q);
    endfunction

    // Updates the shadow state for one accepted vertex and queues a result
    // when the vertex closes the polygon.
    function automatic void predict_vertex(longint x, longint y, bit last);
        centroid_t res;
        longint    den;
        if (poly_count == 0) begin
            poly_first_x = x;
            poly_first_y = y;
            poly_prev_x  = x;
            poly_prev_y  = y;
            poly_count   = 1;
        end else if (poly_count < MAX_V) begin
            add_edge(poly_prev_x, poly_prev_y, x, y);
            poly_prev_x = x;
            poly_prev_y = y;
            poly_count++;
        end else begin
            poly_count = MAX_V + 1;
        end
        if (last) begin
            res.cx = '0;
            res.cy = '0;
            res.da = '0;
            if (poly_count > MAX_V) begin
                res.st = ST_OVF;
            end else begin
                add_edge(poly_prev_x, poly_prev_y, poly_first_x, poly_first_y);
                if (poly_area == 0) begin
                    res.st = ST_ZERO;
                end else begin
                    den    = 3 * longint'(poly_area);
                    res.cx = OUT_W'(fixed_quotient(longint'(poly_wx), den));
                    res.cy = OUT_W'(fixed_quotient(longint'(poly_wy), den));
                    res.da = poly_area;
                    res.st = ST_OK;
                end
            end
            pending_centroids.insert(pending_centroids.size(), res);
            clear_polygon();
        end
    endfunction

    // Offers one vertex beat after a random gap and returns on the edge that
    // accepts it. Valid is assigned once per time step, so back-to-back beats
    // keep it high across the boundary.
    task automatic send_vertex(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y, input bit last);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_x_coord     <= x;
        s_y_coord     <= y;
        s_last_vertex <= last;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        predict_vertex(x, y, last);
    endtask

    // Random coordinate: full range, a small window, or pinned to an extreme.
    function automatic logic signed [COORD_W-1:0] rand_coord(int mode);
        case (mode)
            0: begin
                return COORD_W'($urandom_range(100) - 50);
            end
            1: begin
                return $urandom_range(1) ? COORD_W'(16'sh7fff - $urandom_range(3))
                                         : COORD_W'(16'sh8000 + $urandom_range(3));
            end
            default: begin
                return COORD_W'($urandom);
            end
        endcase
    endfunction

    // Mostly well-formed polygons of three to eight vertices; a few degenerate
    // ones with one or two vertices or repeated points.
    task automatic send_random_polygon();
        int                        len, mode;
        logic signed [COORD_W-1:0] x, y;
        len  = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
        mode = $urandom_range(3);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(15) == 0 && i > 0) begin
                x = s_x_coord;
                y = s_y_coord;
            end else begin
                x = rand_coord(mode);
                y = rand_coord(mode);
            end
            send_vertex(x, y, i == len - 1);
        end
    endtask

    task automatic test_extremes();
        // Counterclockwise triangle spanning the full coordinate range.
        send_vertex(16'sh8000, 16'sh8000, 1'b0);
        send_vertex(16'sh7fff, 16'sh8000, 1'b0);
        send_vertex(16'sh7fff, 16'sh7fff, 1'b1);
        // The four corners of the full range clockwise give a negative doubled area.
        send_vertex(16'sh8000, 16'sh8000, 1'b0);
        send_vertex(16'sh8000, 16'sh7fff, 1'b0);
        send_vertex(16'sh7fff, 16'sh7fff, 1'b0);
        send_vertex(16'sh7fff, 16'sh8000, 1'b1);
    endtask

    task automatic test_zero_area();
        // A lone vertex, a two-point segment and three collinear points.
        send_vertex(16'sd123, -16'sd77, 1'b1);
        send_vertex(16'sd5, 16'sd5, 1'b0);
        send_vertex(-16'sd9, 16'sd40, 1'b1);
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd10, 16'sd10, 1'b0);
        send_vertex(16'sd20, 16'sd20, 1'b1);
    endtask

    task automatic test_saturation();
        // Tiny triangles far from the origin put the centroid near the ends of the
        // 24-bit range, once toward each end.
        send_vertex(16'sh7fff, 16'sh7fff, 1'b0);
        send_vertex(16'sh7ffe, 16'sh7fff, 1'b0);
        send_vertex(16'sh7fff, 16'sh7ffe, 1'b1);
        send_vertex(16'sh8000, 16'sh8000, 1'b0);
        send_vertex(16'sh8001, 16'sh8000, 1'b0);
        send_vertex(16'sh8000, 16'sh8001, 1'b1);
    endtask

    task automatic test_vertex_overflow();
        // One vertex more than the maximum count.
        for (int i = 0; i <= MAX_V; i++) begin
            send_vertex(COORD_W'($urandom_range(200) - 100),
                        COORD_W'($urandom_range(200) - 100), i == MAX_V);
        end
    endtask

    task automatic test_random(input int idle, input int stall, input int n_items);
        int start_count;
        idle_pct    = idle;
        stall_pct   = stall;
        start_count = 0;
        while (start_count < n_items) begin
            send_random_polygon();
            start_count += 5;
        end
    endtask

    task automatic test_backpressure();
        // The receiver holds off for a long stretch while the sender keeps
        // offering polygons, so the output register fills and the input stalls.
        idle_pct  = 0;
        stall_pct = 0;
        fork
            begin
                ready_hold = 1'b1;
                repeat (HOLD_LEN) @(posedge aclk);
                ready_hold = 1'b0;
            end
            begin
                repeat (20) send_random_polygon();
            end
        join
    endtask

    initial begin
        fail_count    = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        ready_hold    = 1'b0;
        quiet_cycles  = 0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_x_coord     = '0;
        s_y_coord     = '0;
        s_last_vertex = 1'b0;
        m_ready       = 1'b0;
        clear_polygon();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_zero_area();
        test_saturation();
        test_vertex_overflow();
        test_random(0, 0, 100);
        test_random(87, 0, 100);
        test_random(0, 87, 100);
        test_random(32, 32, 100);
        test_backpressure();

        s_valid <= 1'b0;
        // The watchdog bounds this wait if a result never arrives.
        while (pending_centroids.size() != 0) @(posedge aclk);
        repeat (DRAIN_LEN) @(posedge aclk);
        if (fail_count == 0 && pending_centroids.size() == 0) begin
            $display("polygon_centroid_shoelace regression: pass");
        end else begin
            $display("polygon_centroid_shoelace regression: fail");
        end
        $finish;
    end

endmodule
